[hdl/assert_macros.svh]
// Assertion macros shared by the precoder RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define MLPP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Clocked check that also holds while reset is asserted.
`define MLPP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define MLPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MLPP_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[hdl/mlpp_pkg.sv]
// Types and constants of the layer-to-port precoder.
`timescale 1ns / 1ps
`default_nettype none

package mlpp_pkg;

    localparam int MAX_DIM   = 4;    // layers and ports handled by the datapath
    localparam int NUM_REGS  = 8;    // weight registers, two per port
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 8;
    localparam int FIELD_W   = 16;
    localparam int WEIGHT_W  = 16;
    localparam int HALF_W    = 32;   // one complex weight inside a register
    localparam int FRAC_BITS = 15;

    // Samples are carried one bit wider than a field so a zero-extended
    // wide sample still fits.
    localparam int X_W     = FIELD_W + 1;
    localparam int PROD_W  = X_W + WEIGHT_W;
    localparam int PAIR_W  = PROD_W + 2;   // two complex products summed
    localparam int ACC_W   = PAIR_W + 1;   // all four layers summed

    typedef logic signed [FIELD_W-1:0]  field_t;
    typedef logic signed [X_W-1:0]      xval_t;
    typedef logic signed [WEIGHT_W-1:0] wval_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [PAIR_W-1:0]   pair_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef struct packed {
        xval_t re;
        xval_t im;
    } xcplx_t;

    typedef struct packed {
        wval_t re;
        wval_t im;
    } wcplx_t;

    // Four real partial products of one complex multiply.
    typedef struct packed {
        prod_t rr;
        prod_t ii;
        prod_t ri;
        prod_t ir;
    } prod4_t;

    typedef struct packed {
        field_t re;
        field_t im;
    } fcplx_t;

    typedef xcplx_t [MAX_DIM-1:0]              xvec_t;
    typedef wcplx_t [MAX_DIM-1:0][MAX_DIM-1:0] weight_mat_t;
    typedef prod4_t [MAX_DIM-1:0][MAX_DIM-1:0] prod_mat_t;
    typedef fcplx_t [MAX_DIM-1:0]              fvec_t;

    // Real part in the low 16 bits, imaginary part in the high 16 bits.
    function automatic wcplx_t weight_half(input logic [HALF_W-1:0] h);
        wcplx_t w;
        w.re = wval_t'(h[WEIGHT_W-1:0]);
        w.im = wval_t'(h[HALF_W-1:WEIGHT_W]);
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/mlpp_weight_regs.sv]
// Weight register file of the precoder, written through the config port.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mlpp_weight_regs
    import mlpp_pkg::*;
#(
    parameter int NUM_PORTS  = 4,
    parameter int NUM_LAYERS = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data,
    output weight_mat_t               weights
);

    logic [REG_W-1:0] w_reg [NUM_REGS];

    // Only registers that feed a live port/layer pair are built.
    for (genvar r = 0; r < NUM_REGS; r++) begin : g_reg
        if ((r / 2) < NUM_PORTS && 2 * (r % 2) < NUM_LAYERS) begin : g_used
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    w_reg[r] <= '0;
                end
                else if (cfg_valid && cfg_index == CFG_IDX_W'(r))
                begin
                    w_reg[r] <= cfg_data;
                end
            end
        end
        else begin : g_unused
            assign w_reg[r] = '0;
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_REGS; r++)
        begin
            weights[r / 2][2 * (r % 2)]     = weight_half(w_reg[r][HALF_W-1:0]);
            weights[r / 2][2 * (r % 2) + 1] = weight_half(w_reg[r][REG_W-1:HALF_W]);
        end
    end

    `MLPP_ASSERT(a_oob_write_ignored, clk, rst_n,
        (cfg_valid && cfg_index >= CFG_IDX_W'(NUM_REGS)) |=> $stable(weights),
        "weight matrix changed on an out-of-range write")

endmodule

`default_nettype wire

[hdl/mlpp_mult.sv]
// Multiply stage: all real partial products of the weight matrix times the layers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mlpp_mult
    import mlpp_pkg::*;
#(
    parameter int NUM_PORTS  = 4,
    parameter int NUM_LAYERS = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire xvec_t        x,
    input  wire weight_mat_t  weights,
    output logic              out_valid,
    input  wire logic         out_ready,
    output prod_mat_t         prods
);

    logic   valid_reg;
    prod4_t prod_reg [MAX_DIM][MAX_DIM];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    for (genvar p = 0; p < MAX_DIM; p++) begin : g_port
        for (genvar l = 0; l < MAX_DIM; l++) begin : g_layer
            if (p < NUM_PORTS && l < NUM_LAYERS) begin : g_mul
                always_ff @(posedge clk)
                begin
                    if (in_valid && in_ready)
                    begin
                        prod_reg[p][l].rr <= x[l].re * weights[p][l].re;
                        prod_reg[p][l].ii <= x[l].im * weights[p][l].im;
                        prod_reg[p][l].ri <= x[l].re * weights[p][l].im;
                        prod_reg[p][l].ir <= x[l].im * weights[p][l].re;
                    end
                end
            end
            else begin : g_zero
                assign prod_reg[p][l] = '0;
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < MAX_DIM; p++)
        begin
            for (int l = 0; l < MAX_DIM; l++)
            begin
                prods[p][l] = prod_reg[p][l];
            end
        end
    end

    `MLPP_ASSERT(a_mult_hold, clk, rst_n,
        (valid_reg && !out_ready) |=> (valid_reg && $stable(prods)),
        "multiply stage lost or changed a stalled word")

endmodule

`default_nettype wire

[hdl/mlpp_accum.sv]
// Sum stages: complex combine, layer sums, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mlpp_accum
    import mlpp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire prod_mat_t prods,
    output logic           out_valid,
    input  wire logic      out_ready,
    output fvec_t          result
);

    localparam acc_t ROUND_ADD = acc_t'(64'sd1 <<< (FRAC_BITS - 1));
    localparam acc_t SAT_HI    = acc_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam acc_t SAT_LO    = acc_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    logic  va_reg;
    logic  vb_reg;
    logic  ready_b;
    pair_t [MAX_DIM-1:0][1:0] re_pair_reg;
    pair_t [MAX_DIM-1:0][1:0] im_pair_reg;
    pair_t [MAX_DIM-1:0][1:0] re_pair_next;
    pair_t [MAX_DIM-1:0][1:0] im_pair_next;
    fvec_t result_reg;
    fvec_t result_next;

    // Round half up by 2^-15, then clamp to the sample range.
    function automatic field_t round_sat(input acc_t a);
        acc_t r;
        acc_t c;
        r = (a + ROUND_ADD) >>> FRAC_BITS;
        priority if (r > SAT_HI)
            c = SAT_HI;
        else if (r < SAT_LO)
            c = SAT_LO;
        else
            c = r;
        return field_t'(c[FIELD_W-1:0]);
    endfunction

    assign ready_b   = !vb_reg || out_ready;
    assign in_ready  = !va_reg || ready_b;
    assign out_valid = vb_reg;
    assign result    = result_reg;

    // Stage A: complex products of a layer pair, summed.
    always_comb
    begin
        for (int p = 0; p < MAX_DIM; p++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                re_pair_next[p][k] = pair_t'(prods[p][2*k].rr) - pair_t'(prods[p][2*k].ii)
                    + pair_t'(prods[p][2*k+1].rr) - pair_t'(prods[p][2*k+1].ii);
                im_pair_next[p][k] = pair_t'(prods[p][2*k].ri) + pair_t'(prods[p][2*k].ir)
                    + pair_t'(prods[p][2*k+1].ri) + pair_t'(prods[p][2*k+1].ir);
            end
        end
    end

    // Stage B: final sum and output formatting.
    always_comb
    begin
        for (int p = 0; p < MAX_DIM; p++)
        begin
            result_next[p].re = round_sat(acc_t'(re_pair_reg[p][0])
                + acc_t'(re_pair_reg[p][1]));
            result_next[p].im = round_sat(acc_t'(im_pair_reg[p][0])
                + acc_t'(im_pair_reg[p][1]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            re_pair_reg <= re_pair_next;
            im_pair_reg <= im_pair_next;
        end
        if (va_reg && ready_b)
        begin
            result_reg <= result_next;
        end
    end

    `MLPP_ASSERT(a_sum_hold, clk, rst_n,
        (va_reg && !ready_b) |=> (va_reg && $stable(re_pair_reg) && $stable(im_pair_reg)),
        "sum stage lost or changed a stalled word")

    `MLPP_ASSERT_NR(a_sum_reset, clk,
        !rst_n |=> (!va_reg && !vb_reg),
        "sum stages hold a word during reset")

endmodule

`default_nettype wire

[hdl/mimo_layer_to_port_precoder_core.sv]
// Top level of the MIMO layer-to-port precoder: input stage and pipeline wiring.
// Each accepted word passes the input, multiply, pair-sum and result registers.
// Throughput: one word per cycle while out_ready is high (fully pipelined multiply).
// Each stage holds its word while downstream stalls and fills bubbles independently.
// Reset: async active low; clears all valid bits and all weights to zero.
// Config port is always ready; a write to an index above 7 is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mimo_layer_to_port_precoder_core
    import mlpp_pkg::*;
#(
    parameter int NUM_PORTS   = 4,
    parameter int NUM_LAYERS  = 4,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // Weight configuration
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data,

    // Layer samples in
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire field_t               layer0_re,
    input  wire field_t               layer0_im,
    input  wire field_t               layer1_re,
    input  wire field_t               layer1_im,
    input  wire field_t               layer2_re,
    input  wire field_t               layer2_im,
    input  wire field_t               layer3_re,
    input  wire field_t               layer3_im,

    // Port samples out
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output field_t                    port0_re,
    output field_t                    port0_im,
    output field_t                    port1_re,
    output field_t                    port1_im,
    output field_t                    port2_re,
    output field_t                    port2_im,
    output field_t                    port3_re,
    output field_t                    port3_im
);

    field_t      f_re [MAX_DIM];
    field_t      f_im [MAX_DIM];
    xvec_t       x_next;
    xvec_t       x_reg;
    logic        s1_valid_reg;
    logic        mult_ready;
    logic        mult_valid;
    logic        accum_ready;
    weight_mat_t weights;
    prod_mat_t   prods;
    fvec_t       result;

    // Weights can be written at any time the port is idle.
    assign cfg_ready = 1'b1;

    assign f_re = '{layer0_re, layer1_re, layer2_re, layer3_re};
    assign f_im = '{layer0_im, layer1_im, layer2_im, layer3_im};

    // Input sample interpretation: narrow samples are sign-extended from
    // their low SAMPLE_BITS bits, wider ones have zero upper bits.
    if (SAMPLE_BITS > FIELD_W) begin : g_wide
        always_comb
        begin
            for (int l = 0; l < MAX_DIM; l++)
            begin
                x_next[l].re = xval_t'({1'b0, f_re[l]});
                x_next[l].im = xval_t'({1'b0, f_im[l]});
            end
        end
    end
    else begin : g_narrow
        always_comb
        begin
            for (int l = 0; l < MAX_DIM; l++)
            begin
                x_next[l].re = xval_t'($signed(f_re[l][SAMPLE_BITS-1:0]));
                x_next[l].im = xval_t'($signed(f_im[l][SAMPLE_BITS-1:0]));
            end
        end
    end

    // Stage 1: input register.
    assign in_ready = !s1_valid_reg || mult_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= x_next;
        end
    end

    mlpp_weight_regs #(
        .NUM_PORTS  (NUM_PORTS),
        .NUM_LAYERS (NUM_LAYERS)
    ) u_weights (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .weights   (weights)
    );

    // Stage 2: 4x4 complex multiply array (unused ports/layers tie to zero).
    mlpp_mult #(
        .NUM_PORTS  (NUM_PORTS),
        .NUM_LAYERS (NUM_LAYERS)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (mult_ready),
        .x         (x_reg),
        .weights   (weights),
        .out_valid (mult_valid),
        .out_ready (accum_ready),
        .prods     (prods)
    );

    // Stages 3 and 4: pair sums, then total, round and saturate.
    mlpp_accum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mult_valid),
        .in_ready  (accum_ready),
        .prods     (prods),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign port0_re = result[0].re;
    assign port0_im = result[0].im;
    assign port1_re = result[1].re;
    assign port1_im = result[1].im;
    assign port2_re = result[2].re;
    assign port2_im = result[2].im;
    assign port3_re = result[3].re;
    assign port3_im = result[3].im;

    `MLPP_ASSERT(a_in_hold, clk, rst_n,
        (s1_valid_reg && !mult_ready) |=> (s1_valid_reg && $stable(x_reg)),
        "input stage lost or changed a stalled word")

    `MLPP_ASSERT(a_latency, clk, rst_n,
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid,
        "word did not reach the output after four free cycles")

endmodule

`default_nettype wire
